@@ sv/rtcaoe_pkg.sv @@
// rtcaoe_pkg: types, constants and small helpers for the alarm time offset encoder
// shared by the delay split stages, the time add stages, the top level and the checker and tb
// no dependencies
package rtcaoe_pkg;

  localparam logic [7:0]  CTRL_ALARM1     = 8'h05;
  localparam logic [7:0]  CTRL_ALARM2     = 8'h06;
  localparam logic [7:0]  ALARM_MASK      = 8'h80;
  localparam logic [21:0] DELAY_MAX       = 22'd2419199;
  localparam logic [21:0] EVERY_MIN_DELAY = 22'd60;
  localparam logic [6:0]  YEAR_NO_LEAP    = 7'd100;

  // reciprocal constants, exact for the value ranges seen at each stage
  localparam int unsigned RECIP60_22_MUL = 4473925;  // ceil(2^28 / 60)
  localparam int unsigned RECIP60_22_SH  = 28;
  localparam int unsigned RECIP60_16_MUL = 69906;    // ceil(2^22 / 60)
  localparam int unsigned RECIP60_16_SH  = 22;
  localparam int unsigned RECIP24_10_MUL = 1366;     // ceil(2^15 / 24)
  localparam int unsigned RECIP24_10_SH  = 15;

  localparam logic [6:0] SIXTY      = 7'd60;
  localparam logic [6:0] ONE_TWENTY = 7'd120;
  localparam logic [5:0] TWENTY_FOUR = 6'd24;
  localparam logic [5:0] FORTY_EIGHT = 6'd48;

  typedef struct packed {
    logic [6:0]  now_year;
    logic [3:0]  now_month;
    logic [4:0]  now_date;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
    logic [5:0]  now_second;
    logic [21:0] delay_seconds;
  } item_t;

  typedef struct packed {
    logic       every_minute;
    logic [5:0] mdays;
    logic [4:0] date;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [5:0] add_s;
    logic [5:0] add_m;
    logic [4:0] add_h;
    logic [4:0] add_d;
  } split_t;

  typedef struct packed {
    logic       every_minute_mode;
    logic [7:0] control_byte;
    logic [7:0] alarm_second_byte;
    logic [7:0] alarm_minute_byte;
    logic [7:0] alarm_hour_byte;
    logic [7:0] alarm_date_byte;
  } result_t;

  // years 0..127: multiple of 4 is leap, except 100
  function automatic logic is_leap(input logic [6:0] year);
    is_leap = (year[1:0] == 2'b00) && (year != YEAR_NO_LEAP);
  endfunction

  // month 0 and 13..15 count as 31-day months
  function automatic logic [5:0] month_days(input logic [3:0] month, input logic leap);
    case (month)
      4'd2:    month_days = leap ? 6'd29 : 6'd28;
      4'd4:    month_days = 6'd30;
      4'd6:    month_days = 6'd30;
      4'd9:    month_days = 6'd30;
      4'd11:   month_days = 6'd30;
      default: month_days = 6'd31;
    endcase
  endfunction

  // two-digit bcd for values below 70
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [2:0] tens;
    logic [6:0] ones;
    if (v >= 7'd60) begin
      tens = 3'd6;
    end else if (v >= 7'd50) begin
      tens = 3'd5;
    end else if (v >= 7'd40) begin
      tens = 3'd4;
    end else if (v >= 7'd30) begin
      tens = 3'd3;
    end else if (v >= 7'd20) begin
      tens = 3'd2;
    end else if (v >= 7'd10) begin
      tens = 3'd1;
    end else begin
      tens = 3'd0;
    end
    ones = v - 7'(tens) * 7'd10;
    to_bcd = {1'b0, tens, ones[3:0]};
  endfunction

endpackage

@@ sv/rtcaoe_if.sv @@
// rtcaoe_in_if and rtcaoe_out_if: valid/ready channels for requests and results
// depends on nothing; payload fields follow rtcaoe_pkg item_t and result_t
interface rtcaoe_in_if;
  logic        valid;
  logic        ready;
  logic [6:0]  now_year;
  logic [3:0]  now_month;
  logic [4:0]  now_date;
  logic [4:0]  now_hour;
  logic [5:0]  now_minute;
  logic [5:0]  now_second;
  logic [21:0] delay_seconds;

  modport source (
    output valid, now_year, now_month, now_date, now_hour, now_minute, now_second,
           delay_seconds,
    input  ready
  );
  modport sink (
    input  valid, now_year, now_month, now_date, now_hour, now_minute, now_second,
           delay_seconds,
    output ready
  );
endinterface

interface rtcaoe_out_if;
  logic       valid;
  logic       ready;
  logic       every_minute_mode;
  logic [7:0] control_byte;
  logic [7:0] alarm_second_byte;
  logic [7:0] alarm_minute_byte;
  logic [7:0] alarm_hour_byte;
  logic [7:0] alarm_date_byte;

  modport source (
    output valid, every_minute_mode, control_byte, alarm_second_byte, alarm_minute_byte,
           alarm_hour_byte, alarm_date_byte,
    input  ready
  );
  modport sink (
    input  valid, every_minute_mode, control_byte, alarm_second_byte, alarm_minute_byte,
           alarm_hour_byte, alarm_date_byte,
    output ready
  );
endinterface

@@ sv/rtcaoe_split.sv @@
// rtcaoe_split: three pipeline stages that saturate the delay and split it into
// days, hours, minutes and seconds by reciprocal multiplies; uses rtcaoe_pkg
module rtcaoe_split (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  rtcaoe_pkg::item_t   up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output rtcaoe_pkg::split_t  dn_data
);

  typedef struct packed {
    logic        every_minute;
    logic [5:0]  mdays;
    logic [4:0]  date;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [21:0] delay;
    logic [15:0] q60;
  } st1_t;

  typedef struct packed {
    logic        every_minute;
    logic [5:0]  mdays;
    logic [4:0]  date;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [5:0]  add_s;
    logic [15:0] q60;
    logic [9:0]  q3600;
  } st2_t;

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  st1_t               s1_r, s1_nxt;
  st2_t               s2_r, s2_nxt;
  rtcaoe_pkg::split_t s3_r, s3_nxt;

  logic [21:0] dsat;
  logic [44:0] prod1;
  logic [21:0] rem_s;
  logic [32:0] prod2;
  logic [15:0] rem_m;
  logic [20:0] prod3;
  logic [4:0]  q24;
  logic [9:0]  rem_h;

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  // stage 1: saturate, every-minute flag, month length, delay / 60
  always_comb begin
    dsat  = (up_data.delay_seconds > rtcaoe_pkg::DELAY_MAX) ? rtcaoe_pkg::DELAY_MAX
                                                              : up_data.delay_seconds;
    prod1 = {23'd0, dsat} * 45'(rtcaoe_pkg::RECIP60_22_MUL);
    s1_nxt.every_minute = (up_data.delay_seconds == rtcaoe_pkg::EVERY_MIN_DELAY);
    s1_nxt.mdays  = rtcaoe_pkg::month_days(up_data.now_month,
                                           rtcaoe_pkg::is_leap(up_data.now_year));
    s1_nxt.date   = up_data.now_date;
    s1_nxt.hour   = up_data.now_hour;
    s1_nxt.minute = up_data.now_minute;
    s1_nxt.second = up_data.now_second;
    s1_nxt.delay  = dsat;
    s1_nxt.q60    = prod1[rtcaoe_pkg::RECIP60_22_SH +: 16];
  end

  // stage 2: seconds remainder, delay / 3600
  always_comb begin
    rem_s = s1_r.delay - 22'(s1_r.q60) * 22'd60;
    prod2 = {17'd0, s1_r.q60} * 33'(rtcaoe_pkg::RECIP60_16_MUL);
    s2_nxt.every_minute = s1_r.every_minute;
    s2_nxt.mdays  = s1_r.mdays;
    s2_nxt.date   = s1_r.date;
    s2_nxt.hour   = s1_r.hour;
    s2_nxt.minute = s1_r.minute;
    s2_nxt.second = s1_r.second;
    s2_nxt.add_s  = rem_s[5:0];
    s2_nxt.q60    = s1_r.q60;
    s2_nxt.q3600  = prod2[rtcaoe_pkg::RECIP60_16_SH +: 10];
  end

  // stage 3: minutes and hours remainders, days
  always_comb begin
    rem_m = s2_r.q60 - 16'(s2_r.q3600) * 16'd60;
    prod3 = {11'd0, s2_r.q3600} * 21'(rtcaoe_pkg::RECIP24_10_MUL);
    q24   = prod3[rtcaoe_pkg::RECIP24_10_SH +: 5];
    rem_h = s2_r.q3600 - 10'(q24) * 10'd24;
    s3_nxt.every_minute = s2_r.every_minute;
    s3_nxt.mdays  = s2_r.mdays;
    s3_nxt.date   = s2_r.date;
    s3_nxt.hour   = s2_r.hour;
    s3_nxt.minute = s2_r.minute;
    s3_nxt.second = s2_r.second;
    s3_nxt.add_s  = s2_r.add_s;
    s3_nxt.add_m  = rem_m[5:0];
    s3_nxt.add_h  = rem_h[4:0];
    s3_nxt.add_d  = q24;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) s1_r <= s1_nxt;
    if (rdy2 && v1_r)     s2_r <= s2_nxt;
    if (rdy3 && v2_r)     s3_r <= s3_nxt;
  end

  assign dn_valid = v3_r;
  assign dn_data  = s3_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !v1_r && !v2_r && !v3_r)
    else $error("pipeline valid bits not cleared by reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !dn_ready |=> v3_r && $stable(s3_r))
    else $error("split output changed while stalled");

  a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> s3_r.add_s < 6'd60 && s3_r.add_m < 6'd60 && s3_r.add_h < 5'd24 &&
             s3_r.add_d < 5'd28)
    else $error("delay split out of range");

endmodule

@@ sv/rtcaoe_add.sv @@
// rtcaoe_add: two pipeline stages that add the split delay to the current time with
// carries, wrap the date, and build the alarm register bytes; uses rtcaoe_pkg
module rtcaoe_add (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  rtcaoe_pkg::split_t   up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output rtcaoe_pkg::result_t  dn_data
);

  typedef struct packed {
    logic       every_minute;
    logic [5:0] mdays;
    logic [4:0] date;
    logic [4:0] hour;
    logic [4:0] add_h;
    logic [4:0] add_d;
    logic       carry_m;
    logic [5:0] r_m;
    logic [5:0] r_s;
  } st4_t;

  logic v4_r, v5_r;
  logic rdy4, rdy5;
  st4_t                s4_r, s4_nxt;
  rtcaoe_pkg::result_t s5_r, s5_nxt;

  logic [6:0] sum_s, sum_m, r_s7, r_m7;
  logic       carry_s, carry_m;
  logic [5:0] sum_h, r_h;
  logic       carry_h;
  logic [6:0] sum_d, div, div2, r_d;

  assign rdy5     = !v5_r || dn_ready;
  assign rdy4     = !v4_r || rdy5;
  assign up_ready = rdy4;

  // stage 4: seconds and minutes, sums may reach twice the modulus for bad inputs
  always_comb begin
    sum_s   = 7'(up_data.second) + 7'(up_data.add_s);
    carry_s = (sum_s >= rtcaoe_pkg::SIXTY);
    if (sum_s >= rtcaoe_pkg::ONE_TWENTY) begin
      r_s7 = sum_s - rtcaoe_pkg::ONE_TWENTY;
    end else if (carry_s) begin
      r_s7 = sum_s - rtcaoe_pkg::SIXTY;
    end else begin
      r_s7 = sum_s;
    end
    sum_m   = 7'(up_data.minute) + 7'(up_data.add_m) + 7'(carry_s);
    carry_m = (sum_m >= rtcaoe_pkg::SIXTY);
    if (sum_m >= rtcaoe_pkg::ONE_TWENTY) begin
      r_m7 = sum_m - rtcaoe_pkg::ONE_TWENTY;
    end else if (carry_m) begin
      r_m7 = sum_m - rtcaoe_pkg::SIXTY;
    end else begin
      r_m7 = sum_m;
    end
    s4_nxt.every_minute = up_data.every_minute;
    s4_nxt.mdays   = up_data.mdays;
    s4_nxt.date    = up_data.date;
    s4_nxt.hour    = up_data.hour;
    s4_nxt.add_h   = up_data.add_h;
    s4_nxt.add_d   = up_data.add_d;
    s4_nxt.carry_m = carry_m;
    s4_nxt.r_m     = r_m7[5:0];
    s4_nxt.r_s     = r_s7[5:0];
  end

  // stage 5: hours, date wrap modulo days plus one, bcd and mode select
  always_comb begin
    sum_h   = 6'(s4_r.hour) + 6'(s4_r.add_h) + 6'(s4_r.carry_m);
    carry_h = (sum_h >= rtcaoe_pkg::TWENTY_FOUR);
    if (sum_h >= rtcaoe_pkg::FORTY_EIGHT) begin
      r_h = sum_h - rtcaoe_pkg::FORTY_EIGHT;
    end else if (carry_h) begin
      r_h = sum_h - rtcaoe_pkg::TWENTY_FOUR;
    end else begin
      r_h = sum_h;
    end
    sum_d = 7'(s4_r.date) + 7'(s4_r.add_d) + 7'(carry_h);
    div   = 7'(s4_r.mdays) + 7'd1;
    div2  = {div[5:0], 1'b0};
    if (sum_d >= div2) begin
      r_d = sum_d - div2;
    end else if (sum_d >= div) begin
      r_d = sum_d - div;
    end else begin
      r_d = sum_d;
    end
    if (r_d == 7'd0) r_d = 7'd1;

    if (s4_r.every_minute) begin
      s5_nxt.every_minute_mode = 1'b1;
      s5_nxt.control_byte      = rtcaoe_pkg::CTRL_ALARM2;
      s5_nxt.alarm_second_byte = 8'h00;
      s5_nxt.alarm_minute_byte = rtcaoe_pkg::ALARM_MASK;
      s5_nxt.alarm_hour_byte   = rtcaoe_pkg::ALARM_MASK;
      s5_nxt.alarm_date_byte   = rtcaoe_pkg::ALARM_MASK;
    end else begin
      s5_nxt.every_minute_mode = 1'b0;
      s5_nxt.control_byte      = rtcaoe_pkg::CTRL_ALARM1;
      s5_nxt.alarm_second_byte = rtcaoe_pkg::to_bcd(7'(s4_r.r_s));
      s5_nxt.alarm_minute_byte = rtcaoe_pkg::to_bcd(7'(s4_r.r_m));
      s5_nxt.alarm_hour_byte   = rtcaoe_pkg::to_bcd(7'(r_h));
      s5_nxt.alarm_date_byte   = rtcaoe_pkg::to_bcd(r_d) | rtcaoe_pkg::ALARM_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= up_valid;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && up_valid) s4_r <= s4_nxt;
    if (rdy5 && v4_r)     s5_r <= s5_nxt;
  end

  assign dn_valid = v5_r;
  assign dn_data  = s5_r;

  a_minute_mode_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && s5_r.every_minute_mode |->
      s5_r.control_byte == rtcaoe_pkg::CTRL_ALARM2 && s5_r.alarm_second_byte == 8'h00)
    else $error("every-minute result with wrong control or seconds byte");

  a_date_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !s5_r.every_minute_mode |->
      s5_r.alarm_date_byte[7] && s5_r.alarm_date_byte[6:0] != 7'd0 &&
      s5_r.control_byte == rtcaoe_pkg::CTRL_ALARM1)
    else $error("alarm 1 date byte without mask bit or zero date");

  a_stage4_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !rdy5 |=> v4_r && $stable(s4_r))
    else $error("stage 4 changed while stalled");

endmodule

@@ sv/rtc_alarm_time_offset_encoder_top.sv @@
// throughput: one request per cycle while results are taken, set by the five-stage pipeline with a ready per stage
// a stalled result holds in the output register while earlier stages keep filling
// reset (rst_n low, synchronous) clears the stage valid bits only; data registers are not reset
// top level: wires the request channel through the delay split and time add stages
// depends on rtcaoe_pkg, rtcaoe_if, rtcaoe_split, rtcaoe_add
module rtc_alarm_time_offset_encoder_top (
  input  logic  clk,
  input  logic  rst_n,
  rtcaoe_in_if.sink    in_ch,
  rtcaoe_out_if.source out_ch
);

  rtcaoe_pkg::item_t   item;
  rtcaoe_pkg::split_t  split_data;
  rtcaoe_pkg::result_t res;
  logic                split_valid, split_ready;

  always_comb begin
    item.now_year      = in_ch.now_year;
    item.now_month     = in_ch.now_month;
    item.now_date      = in_ch.now_date;
    item.now_hour      = in_ch.now_hour;
    item.now_minute    = in_ch.now_minute;
    item.now_second    = in_ch.now_second;
    item.delay_seconds = in_ch.delay_seconds;
  end

  rtcaoe_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_data  (item),
    .dn_valid (split_valid),
    .dn_ready (split_ready),
    .dn_data  (split_data)
  );

  rtcaoe_add u_add (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (split_valid),
    .up_ready (split_ready),
    .up_data  (split_data),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_data  (res)
  );

  assign out_ch.every_minute_mode = res.every_minute_mode;
  assign out_ch.control_byte      = res.control_byte;
  assign out_ch.alarm_second_byte = res.alarm_second_byte;
  assign out_ch.alarm_minute_byte = res.alarm_minute_byte;
  assign out_ch.alarm_hour_byte   = res.alarm_hour_byte;
  assign out_ch.alarm_date_byte   = res.alarm_date_byte;

endmodule

@@ verif/rtcaoe_alarm_checker.sv @@
// rtcaoe_alarm_checker: watches the request and result channels of the alarm offset encoder,
// works out the alarm register bytes for every accepted request and compares them in order
// depends on rtcaoe_pkg (item_t, result_t, the delay limits and the control and mask constants)
module rtcaoe_alarm_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  rtcaoe_pkg::item_t   in_req,
  input  logic                out_valid,
  input  logic                out_ready,
  input  rtcaoe_pkg::result_t out_res,
  output int                  mismatches,
  output int                  pending,
  output int                  checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SEC_PER_DAY  = 86400;
  localparam int unsigned SEC_PER_HOUR = 3600;
  localparam int          REPORT_LIMIT = 10;

  // month 0 and 13..15 behave as 31-day months
  localparam int unsigned DAYS_IN_MONTH [16] = '{31, 31, 28, 31, 30, 31, 30, 31,
                                                 31, 30, 31, 30, 31, 31, 31, 31};

  rtcaoe_pkg::result_t alarm_bytes_q [$];

  function automatic logic [7:0] packed_bcd(input int unsigned v);
    packed_bcd = 8'(((v / 10) << 4) | (v % 10));
  endfunction

  function automatic rtcaoe_pkg::result_t alarm_bytes_for(input rtcaoe_pkg::item_t q);
    rtcaoe_pkg::result_t r;
    int unsigned delay, year, mdays, sum, carry;
    int unsigned add_s, add_m, add_h, add_d;
    int unsigned sec_r, min_r, hr_r, day_r;
    logic        leap;
    if (q.delay_seconds == rtcaoe_pkg::EVERY_MIN_DELAY) begin
      r.every_minute_mode = 1'b1;
      r.control_byte      = rtcaoe_pkg::CTRL_ALARM2;
      r.alarm_second_byte = 8'h00;
      r.alarm_minute_byte = rtcaoe_pkg::ALARM_MASK;
      r.alarm_hour_byte   = rtcaoe_pkg::ALARM_MASK;
      r.alarm_date_byte   = rtcaoe_pkg::ALARM_MASK;
      return r;
    end
    delay = q.delay_seconds;
    if (delay > rtcaoe_pkg::DELAY_MAX) delay = rtcaoe_pkg::DELAY_MAX;
    add_s = delay % 60;
    add_m = (delay / 60) % 60;
    add_h = (delay / SEC_PER_HOUR) % 24;
    add_d = delay / SEC_PER_DAY;

    year  = q.now_year;
    leap  = (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
    mdays = DAYS_IN_MONTH[q.now_month];
    if (q.now_month == 4'd2 && leap) mdays = 29;

    sum   = q.now_second + add_s;
    carry = (sum >= 60) ? 1 : 0;
    sec_r = sum % 60;
    sum   = q.now_minute + add_m + carry;
    carry = (sum >= 60) ? 1 : 0;
    min_r = sum % 60;
    sum   = q.now_hour + add_h + carry;
    carry = (sum >= 24) ? 1 : 0;
    hr_r  = sum % 24;
    // carry out of the date has nowhere to go
    sum   = q.now_date + add_d + carry;
    day_r = sum % (mdays + 1);
    if (day_r == 0) day_r = 1;

    r.every_minute_mode = 1'b0;
    r.control_byte      = rtcaoe_pkg::CTRL_ALARM1;
    r.alarm_second_byte = packed_bcd(sec_r);
    r.alarm_minute_byte = packed_bcd(min_r);
    r.alarm_hour_byte   = packed_bcd(hr_r);
    r.alarm_date_byte   = packed_bcd(day_r) | rtcaoe_pkg::ALARM_MASK;
    return r;
  endfunction

  assign pending = alarm_bytes_q.size();

  always @(posedge clk) begin
    rtcaoe_pkg::result_t want;
    logic                bad;
    if (!rst_n) begin
      mismatches = 0;
      checked    = 0;
    end else begin
      if (in_valid && in_ready) alarm_bytes_q.push_back(alarm_bytes_for(in_req));
      if (out_valid && out_ready) begin
        if (alarm_bytes_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected result %0b %02h %02h %02h %02h %02h",
                     $time, out_res.every_minute_mode, out_res.control_byte,
                     out_res.alarm_second_byte, out_res.alarm_minute_byte,
                     out_res.alarm_hour_byte, out_res.alarm_date_byte);
        end else begin
          want = alarm_bytes_q.pop_front();
          checked++;
          bad = (out_res.every_minute_mode !== want.every_minute_mode)
             || (out_res.control_byte      !== want.control_byte)
             || (out_res.alarm_second_byte !== want.alarm_second_byte)
             || (out_res.alarm_minute_byte !== want.alarm_minute_byte)
             || (out_res.alarm_hour_byte   !== want.alarm_hour_byte)
             || (out_res.alarm_date_byte   !== want.alarm_date_byte);
          if (bad) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: mismatch mode/ctrl/sec/min/hr/date expected %0b %02h %02h %02h %02h %02h",
                       $time, want.every_minute_mode, want.control_byte,
                       want.alarm_second_byte, want.alarm_minute_byte,
                       want.alarm_hour_byte, want.alarm_date_byte);
              $display("%0t:   got %0b %02h %02h %02h %02h %02h",
                       $time, out_res.every_minute_mode, out_res.control_byte,
                       out_res.alarm_second_byte, out_res.alarm_minute_byte,
                       out_res.alarm_hour_byte, out_res.alarm_date_byte);
            end
          end
        end
      end
    end
  end

endmodule

@@ verif/tb.sv @@
// tb: drives calendar time and delay requests into rtc_alarm_time_offset_encoder_top with
// random gaps and result stalls, and gives the verdict from the alarm checker's count
// depends on rtcaoe_pkg, rtcaoe_if, rtcaoe_alarm_checker and the block's top level
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 800;
  localparam int LONG_HOLD       = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int MAX_GAP         = 11;

  logic clk;
  logic rst_n;

  rtcaoe_in_if  in_ch();
  rtcaoe_out_if out_ch();

  int   mismatches, pending, checked;
  int   sent, minute_mode_sent, saturated_sent, wild_sent;
  int   idle_cycles;
  logic tx_eager;
  logic hold_req;

  rtc_alarm_time_offset_encoder_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rtcaoe_alarm_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_req     ({in_ch.now_year, in_ch.now_month, in_ch.now_date, in_ch.now_hour,
                  in_ch.now_minute, in_ch.now_second, in_ch.delay_seconds}),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_res    ({out_ch.every_minute_mode, out_ch.control_byte, out_ch.alarm_second_byte,
                  out_ch.alarm_minute_byte, out_ch.alarm_hour_byte, out_ch.alarm_date_byte}),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // one request: optional gap with valid low, then offer until accepted
  task automatic send_time_request(input rtcaoe_pkg::item_t q);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.now_year      <= q.now_year;
    in_ch.now_month     <= q.now_month;
    in_ch.now_date      <= q.now_date;
    in_ch.now_hour      <= q.now_hour;
    in_ch.now_minute    <= q.now_minute;
    in_ch.now_second    <= q.now_second;
    in_ch.delay_seconds <= q.delay_seconds;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
    if (q.delay_seconds == rtcaoe_pkg::EVERY_MIN_DELAY) minute_mode_sent++;
    else if (q.delay_seconds > rtcaoe_pkg::DELAY_MAX) saturated_sent++;
    if (q.now_year > 7'd99 || q.now_month == 4'd0 || q.now_month > 4'd12 || q.now_date == 5'd0
        || q.now_hour > 5'd23 || q.now_minute > 6'd59 || q.now_second > 6'd59)
      wild_sent++;
  endtask

  task automatic send_time(input int y, input int mo, input int d, input int h,
                           input int mi, input int s, input int dly);
    rtcaoe_pkg::item_t q;
    q.now_year      = 7'(y);
    q.now_month     = 4'(mo);
    q.now_date      = 5'(d);
    q.now_hour      = 5'(h);
    q.now_minute    = 6'(mi);
    q.now_second    = 6'(s);
    q.delay_seconds = 22'(dly);
    send_time_request(q);
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic rtcaoe_pkg::item_t random_time_request();
    rtcaoe_pkg::item_t q;
    int unsigned       kind, dk;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      q.now_year   = 7'($urandom_range(0, 99));
      q.now_month  = 4'($urandom_range(1, 12));
      q.now_date   = 5'($urandom_range(1, 31));
      q.now_hour   = 5'($urandom_range(0, 23));
      q.now_minute = 6'($urandom_range(0, 59));
      q.now_second = 6'($urandom_range(0, 59));
    end else begin
      q.now_year   = 7'($urandom);
      q.now_month  = 4'($urandom);
      q.now_date   = 5'($urandom);
      q.now_hour   = 5'($urandom);
      q.now_minute = 6'($urandom);
      q.now_second = 6'($urandom);
    end
    // close to rollover so the carries chain up to the date
    if (kind >= 55 && kind < 80) begin
      q.now_second = 6'($urandom_range(55, 59));
      q.now_minute = 6'($urandom_range(55, 59));
      q.now_hour   = 5'($urandom_range(20, 23));
      q.now_date   = 5'($urandom_range(27, 31));
    end
    dk = $urandom_range(0, 99);
    if (dk < 8)       q.delay_seconds = rtcaoe_pkg::EVERY_MIN_DELAY;
    else if (dk < 16) q.delay_seconds = 22'($urandom_range(2419200, 4194303));
    else if (dk < 20) q.delay_seconds = rtcaoe_pkg::DELAY_MAX - 22'($urandom_range(0, 3));
    else if (dk < 25) q.delay_seconds = 22'($urandom_range(58, 62));
    else if (dk < 60) q.delay_seconds = 22'($urandom_range(0, 86399));
    else              q.delay_seconds = 22'($urandom_range(0, 2419199));
    return q;
  endfunction

  // acceptance watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
        $display("rtc_alarm_time_offset_encoder_top verification failed");
        $finish;
      end
    end
  end

  // result side: random stalls per result, eager stretches, and one long hold on request
  initial begin
    int  w;
    logic rx_eager;
    logic held;
    out_ch.ready = 1'b0;
    rx_eager     = 1'b0;
    held         = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_eager = !rx_eager;
      if (hold_req && !held) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        held = 1'b1;
      end
      w = rx_eager ? 0 : $urandom_range(0, MAX_GAP);
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.now_year      = '0;
    in_ch.now_month     = '0;
    in_ch.now_date      = '0;
    in_ch.now_hour      = '0;
    in_ch.now_minute    = '0;
    in_ch.now_second    = '0;
    in_ch.delay_seconds = '0;
    tx_eager            = 1'b0;
    hold_req            = 1'b0;
    sent                = 0;
    minute_mode_sent    = 0;
    saturated_sent      = 0;
    wild_sent           = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners
    send_time(0, 0, 0, 0, 0, 0, 0);
    send_time(21, 6, 15, 12, 30, 30, 60);
    send_time(21, 6, 15, 12, 30, 30, 59);
    send_time(21, 6, 15, 12, 30, 30, 61);
    send_time(99, 12, 31, 23, 59, 59, 1);
    send_time(4, 2, 28, 23, 59, 59, 1);
    send_time(1, 2, 28, 23, 59, 59, 1);
    send_time(0, 2, 28, 23, 59, 59, 1);
    send_time(100, 2, 28, 23, 59, 59, 1);
    send_time(23, 4, 30, 10, 0, 0, 86400);
    send_time(23, 0, 31, 0, 0, 0, 86400);
    send_time(23, 13, 31, 0, 0, 0, 86400);
    send_time(23, 15, 30, 23, 0, 0, 3600);
    send_time(50, 7, 1, 0, 0, 0, 86399);
    send_time(50, 7, 1, 0, 0, 0, 3599);
    send_time(50, 7, 20, 5, 5, 5, 2419199);
    send_time(50, 7, 20, 5, 5, 5, 2419200);
    send_time(50, 7, 20, 5, 5, 5, 22'h3FFFFF);
    send_time(127, 15, 31, 31, 63, 63, 22'h3FFFFF);
    send_time(127, 15, 31, 31, 63, 63, 0);
    send_time(8, 9, 31, 23, 63, 63, 60);
    send_time(99, 11, 30, 31, 59, 59, 1);
    wait_results_drained();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if ($urandom_range(0, 29) == 0) tx_eager = !tx_eager;
      // fill the pipeline against a stalled result side
      if (n == 300) begin
        tx_eager = 1'b1;
        hold_req = 1'b1;
      end
      if (n == 550) wait_results_drained();
      send_time_request(random_time_request());
    end
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d requests: %0d every-minute, %0d saturating delays",
             sent, minute_mode_sent, saturated_sent);
    $display("%0d requests with fields out of range, checked %0d alarm results, %0d mismatches",
             wild_sent, checked, mismatches);
    if (mismatches == 0) begin
      $display("rtc_alarm_time_offset_encoder_top verification clean");
    end else begin
      $display("rtc_alarm_time_offset_encoder_top verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rtcaoe_pkg.sv
sv/rtcaoe_if.sv
sv/rtcaoe_split.sv
sv/rtcaoe_add.sv
sv/rtc_alarm_time_offset_encoder_top.sv
verif/rtcaoe_alarm_checker.sv
verif/tb.sv
